// ===== rtl/core/sparse_triplet_transpose_defines.svh =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose assertion macros
// Shared property forms for the concurrent checks of the transpose block.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TRIPLET_TRANSPOSE_DEFINES_SVH
`define SPARSE_TRIPLET_TRANSPOSE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/stt_pkg.sv =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose package
// Widths, defaults, register codes, queue item and control types.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int IDX_W     = 8;
  localparam int DATA_W    = 32;
  localparam int CFG_W     = 9;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

  localparam int DEF_MAX_NONZERO = 64;
  localparam int DEF_MAX_DIM     = 256;
  localparam int DEF_VALUE_WIDTH = 32;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [0:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]  row_index;
    logic [IDX_W-1:0]  col_index;
    logic [DATA_W-1:0] value;
    logic              keep;
    logic              last;
  } stt_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } stt_qstat_t;

  typedef struct packed {
    logic clearing;
    logic emitting;
  } stt_bstat_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_COUNT,
    B_PREFIX,
    B_SC_RD,
    B_SC_COL,
    B_SC_WR,
    B_EM_RD,
    B_EM_LD,
    B_EM_WAIT
  } back_state_t;

endpackage

// ===== rtl/core/stt_if.sv =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose channels
// Valid/ready channels for source triplets and transposed triplets.
// ----------------------------------------------------------------------------
interface stt_in_if;
  import stt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [IDX_W-1:0]  row_index;
  logic        [IDX_W-1:0]  col_index;
  logic signed [DATA_W-1:0] value;
  logic                     last;

  modport source (output valid, row_index, col_index, value, last, input ready);
  modport sink   (input valid, row_index, col_index, value, last, output ready);
endinterface

interface stt_out_if;
  import stt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic        [IDX_W-1:0]  out_row;
  logic        [IDX_W-1:0]  out_col;
  logic signed [DATA_W-1:0] out_value;
  logic                     out_last;

  modport source (output valid, out_row, out_col, out_value, out_last, input ready);
  modport sink   (input valid, out_row, out_col, out_value, out_last, output ready);
endinterface

// ===== rtl/core/stt_front.sv =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose front end
// Holds the dimension registers, takes source triplets and marks the ones
// whose indices fall inside the matrix before queuing them.
// ----------------------------------------------------------------------------
module stt_front #(
  parameter int MAX_DIM = stt_pkg::DEF_MAX_DIM
) (
  input  logic                         clk,
  input  logic                         rst_n,
  stt_in_if.sink                       in_port,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [stt_pkg::PADDR_W-1:0]  paddr,
  input  logic [stt_pkg::PDATA_W-1:0]  pwdata,
  output logic [stt_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  stt_pkg::stt_qstat_t          q_stat,
  input  stt_pkg::stt_bstat_t          b_stat,
  output logic                         push_valid,
  output stt_pkg::stt_item_t           push_data
);
  import stt_pkg::*;

  logic [CFG_W-1:0] num_rows_r, num_rows_nxt;
  logic [CFG_W-1:0] num_cols_r, num_cols_nxt;
  cfg_reg_t         reg_sel;
  logic             cfg_wr;
  logic             in_range;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_t'(paddr[PADDR_W-1]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    num_rows_nxt = num_rows_r;
    num_cols_nxt = num_cols_r;
    prdata       = '0;
    unique case (reg_sel)
      REG_NUM_ROWS: begin
        prdata = PDATA_W'(num_rows_r);
        if (cfg_wr) begin
          num_rows_nxt = pwdata[CFG_W-1:0];
        end
      end
      REG_NUM_COLS: begin
        prdata = PDATA_W'(num_cols_r);
        if (cfg_wr) begin
          num_cols_nxt = pwdata[CFG_W-1:0];
        end
      end
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= CFG_RESET;
      num_cols_r <= CFG_RESET;
    end else begin
      num_rows_r <= num_rows_nxt;
      num_cols_r <= num_cols_nxt;
    end
  end

  // mark for dropping the triplets outside the active matrix or outside the column table
  assign in_range = (CFG_W'(in_port.row_index) < num_rows_r) &&
                    (CFG_W'(in_port.col_index) < num_cols_r) &&
                    (32'(in_port.row_index) < MAX_DIM) &&
                    (32'(in_port.col_index) < MAX_DIM);

  assign in_port.ready = !q_stat.full && !b_stat.clearing;
  assign push_valid    = in_port.valid && in_port.ready;

  always_comb begin
    push_data.row_index = in_port.row_index;
    push_data.col_index = in_port.col_index;
    push_data.value     = in_port.value;
    push_data.keep      = in_range;
    push_data.last      = in_port.last;
  end

endmodule

// ===== rtl/core/stt_queue.sv =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose queue
// Short FIFO between the front end and the transpose engine.
// ----------------------------------------------------------------------------
module stt_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  stt_pkg::stt_item_t  push_data,
  output logic                pop_valid,
  input  logic                pop_ready,
  output stt_pkg::stt_item_t  pop_data,
  output stt_pkg::stt_qstat_t q_stat
);
  import stt_pkg::*;

  localparam int QA_W = $clog2(QUEUE_DEPTH);
  localparam int QL_W = $clog2(QUEUE_DEPTH + 1);

  stt_item_t        entry_r [QUEUE_DEPTH];
  logic [QA_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QL_W-1:0]  level_r, level_nxt;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (level_r == QL_W'(QUEUE_DEPTH));
  assign q_stat.empty = (level_r == '0);
  assign pop_valid    = !q_stat.empty;
  assign pop_data     = entry_r[rd_ptr_r];
  assign do_push      = push_valid && !q_stat.full;
  assign do_pop       = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? QA_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? QA_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    level_nxt  = level_r;
    if (do_push && !do_pop) begin
      level_nxt = QL_W'(level_r + 1'b1);
    end else if (do_pop && !do_push) begin
      level_nxt = QL_W'(level_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      level_r  <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/core/stt_back.sv =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose engine
// Stores and counts kept triplets, then on the last one runs the column
// prefix sum, scatters triplets to their transposed slots and emits them.
// ----------------------------------------------------------------------------
module stt_back #(
  parameter int MAX_NONZERO = stt_pkg::DEF_MAX_NONZERO,
  parameter int MAX_DIM     = stt_pkg::DEF_MAX_DIM,
  parameter int VALUE_WIDTH = stt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  stt_pkg::stt_item_t  pop_data,
  output stt_pkg::stt_bstat_t b_stat,
  stt_out_if.source           out_port
);
  import stt_pkg::*;

  localparam int NZ_AW  = (MAX_NONZERO > 1) ? $clog2(MAX_NONZERO) : 1;
  localparam int CNT_W  = $clog2(MAX_NONZERO + 1);
  localparam int DIM_AW = $clog2(MAX_DIM);
  localparam int ENT_W  = 2 * IDX_W + VALUE_WIDTH;
  localparam int HI_LSB = ENT_W - IDX_W;
  localparam int MD_LSB = ENT_W - 2 * IDX_W;

  back_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [CNT_W-1:0]  p_r, p_nxt;
  logic [DIM_AW:0]   pf_r, pf_nxt;
  logic [DIM_AW-1:0] pf_d_r, pf_d_nxt;
  logic              pf_v_r, pf_v_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [IDX_W-1:0]  col_r, col_nxt;
  logic              last_r, last_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [ENT_W-1:0]  out_ent_r;
  logic              out_load;

  logic              store_ok;
  logic              p_is_last;
  logic              pf_done;
  logic [IDX_W-1:0]  st_col;

  logic [ENT_W-1:0]  st_mem [MAX_NONZERO];
  logic              st_we, st_re;
  logic [NZ_AW-1:0]  st_wa, st_ra;
  logic [ENT_W-1:0]  st_wd, st_q;

  logic [CNT_W-1:0]  cnt_mem [MAX_DIM];
  logic              cnt_we, cnt_re;
  logic [DIM_AW-1:0] cnt_wa, cnt_ra;
  logic [CNT_W-1:0]  cnt_wd, cnt_q;

  logic [NZ_AW-1:0]  sta_mem [MAX_DIM];
  logic              sta_we, sta_re;
  logic [DIM_AW-1:0] sta_wa, sta_ra;
  logic [NZ_AW-1:0]  sta_wd, sta_q;

  logic [ENT_W-1:0]  slot_mem [MAX_NONZERO];
  logic              slot_we, slot_re;
  logic [NZ_AW-1:0]  slot_wa, slot_ra;
  logic [ENT_W-1:0]  slot_wd, slot_q;

  assign store_ok  = pop_valid && pop_data.keep && (loaded_r < CNT_W'(MAX_NONZERO));
  assign p_is_last = (CNT_W'(p_r + 1'b1) == loaded_r);
  assign pf_done   = pf_v_r && (pf_d_r == DIM_AW'(MAX_DIM - 1));
  assign st_col    = st_q[MD_LSB +: IDX_W];

  assign b_stat.clearing = (state_r == B_CLEAR);
  assign b_stat.emitting = (state_r == B_EM_RD) || (state_r == B_EM_LD) ||
                           (state_r == B_EM_WAIT);

  assign out_port.valid     = out_valid_r;
  assign out_port.out_last  = out_last_r;
  assign out_port.out_row   = out_ent_r[HI_LSB +: IDX_W];
  assign out_port.out_col   = out_ent_r[MD_LSB +: IDX_W];
  assign out_port.out_value = DATA_W'(out_ent_r[VALUE_WIDTH-1:0]);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_CLEAR: begin
        if (pf_r[DIM_AW-1:0] == DIM_AW'(MAX_DIM - 1)) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (store_ok) begin
          state_nxt = B_COUNT;
        end else if (pop_valid && pop_data.last && (loaded_r != '0)) begin
          state_nxt = B_PREFIX;
        end
      end
      B_COUNT:   state_nxt = last_r ? B_PREFIX : B_IDLE;
      B_PREFIX: begin
        if (pf_done) begin
          state_nxt = B_SC_RD;
        end
      end
      B_SC_RD:   state_nxt = B_SC_COL;
      B_SC_COL:  state_nxt = B_SC_WR;
      B_SC_WR:   state_nxt = p_is_last ? B_EM_RD : B_SC_RD;
      B_EM_RD:   state_nxt = B_EM_LD;
      B_EM_LD:   state_nxt = B_EM_WAIT;
      B_EM_WAIT: begin
        if (out_port.ready) begin
          state_nxt = out_last_r ? B_IDLE : B_EM_RD;
        end
      end
      default:   state_nxt = B_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    loaded_nxt    = loaded_r;
    p_nxt         = p_r;
    pf_nxt        = pf_r;
    pf_d_nxt      = pf_d_r;
    pf_v_nxt      = 1'b0;
    run_nxt       = run_r;
    col_nxt       = col_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_load      = 1'b0;
    pop_ready     = 1'b0;

    st_we   = 1'b0;
    st_wa   = loaded_r[NZ_AW-1:0];
    st_wd   = {pop_data.row_index, pop_data.col_index, VALUE_WIDTH'(pop_data.value)};
    st_re   = 1'b0;
    st_ra   = p_r[NZ_AW-1:0];
    cnt_we  = 1'b0;
    cnt_wa  = pf_d_r;
    cnt_wd  = '0;
    cnt_re  = 1'b0;
    cnt_ra  = DIM_AW'(pop_data.col_index);
    sta_we  = 1'b0;
    sta_wa  = pf_d_r;
    sta_wd  = run_r[NZ_AW-1:0];
    sta_re  = 1'b0;
    sta_ra  = DIM_AW'(st_col);
    slot_we = 1'b0;
    slot_wa = sta_q;
    slot_wd = {st_col, st_q[HI_LSB +: IDX_W], st_q[VALUE_WIDTH-1:0]};
    slot_re = 1'b0;
    slot_ra = p_r[NZ_AW-1:0];

    unique case (state_r)
      B_CLEAR: begin
        cnt_we = 1'b1;
        cnt_wa = pf_r[DIM_AW-1:0];
        pf_nxt = (pf_r[DIM_AW-1:0] == DIM_AW'(MAX_DIM - 1)) ? '0 : pf_r + 1'b1;
      end
      B_IDLE: begin
        pop_ready = 1'b1;
        pf_nxt    = '0;
        run_nxt   = '0;
        if (store_ok) begin
          st_we    = 1'b1;
          cnt_re   = 1'b1;
          col_nxt  = pop_data.col_index;
          last_nxt = pop_data.last;
        end
      end
      B_COUNT: begin
        cnt_we     = 1'b1;
        cnt_wa     = DIM_AW'(col_r);
        cnt_wd     = CNT_W'(cnt_q + 1'b1);
        loaded_nxt = CNT_W'(loaded_r + 1'b1);
        pf_nxt     = '0;
        run_nxt    = '0;
      end
      B_PREFIX: begin
        // read one column count per cycle, write its start in the following cycle
        if (pf_r < (DIM_AW + 1)'(MAX_DIM)) begin
          cnt_re   = 1'b1;
          cnt_ra   = pf_r[DIM_AW-1:0];
          pf_nxt   = pf_r + 1'b1;
          pf_d_nxt = pf_r[DIM_AW-1:0];
          pf_v_nxt = 1'b1;
        end
        if (pf_v_r) begin
          sta_we  = 1'b1;
          cnt_we  = 1'b1;
          run_nxt = CNT_W'(run_r + cnt_q);
        end
        if (pf_done) begin
          p_nxt = '0;
        end
      end
      B_SC_RD: begin
        st_re = 1'b1;
      end
      B_SC_COL: begin
        sta_re = 1'b1;
      end
      B_SC_WR: begin
        slot_we = 1'b1;
        sta_we  = 1'b1;
        sta_wa  = DIM_AW'(st_col);
        sta_wd  = NZ_AW'(sta_q + 1'b1);
        p_nxt   = p_is_last ? '0 : CNT_W'(p_r + 1'b1);
      end
      B_EM_RD: begin
        slot_re = 1'b1;
      end
      B_EM_LD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = p_is_last;
      end
      B_EM_WAIT: begin
        if (out_port.ready) begin
          out_valid_nxt = 1'b0;
          p_nxt         = CNT_W'(p_r + 1'b1);
          if (out_last_r) begin
            loaded_nxt = '0;
          end
        end
      end
      default: begin
        pf_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_CLEAR;
      loaded_r    <= '0;
      p_r         <= '0;
      pf_r        <= '0;
      pf_d_r      <= '0;
      pf_v_r      <= 1'b0;
      run_r       <= '0;
      col_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      p_r         <= p_nxt;
      pf_r        <= pf_nxt;
      pf_d_r      <= pf_d_nxt;
      pf_v_r      <= pf_v_nxt;
      run_r       <= run_nxt;
      col_r       <= col_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ent_r <= slot_q;
    end
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_wa] <= st_wd;
    end
    if (st_re) begin
      st_q <= st_mem[st_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_q <= cnt_mem[cnt_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (sta_we) begin
      sta_mem[sta_wa] <= sta_wd;
    end
    if (sta_re) begin
      sta_q <= sta_mem[sta_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_q <= slot_mem[slot_ra];
    end
  end

endmodule

// ===== rtl/core/sparse_triplet_transpose.sv =====
// ----------------------------------------------------------------------------
// Sparse triplet transpose
// Takes the nonzero triplets of a row-major sparse matrix, one transfer per
// cycle while the queue has room, into a four-entry queue, and returns the
// transposed triplets sorted by source column (load order within a column),
// with out_last on the final one. Triplets outside num_rows x num_cols, or
// beyond MAX_NONZERO in one matrix, are dropped; a last triplet still closes
// the matrix even if it is dropped, and an empty matrix returns nothing. The
// engine stores each kept triplet with a column count read-modify-write.
// After the last one it runs the column prefix sum, scatters each triplet
// (store, start and slot memory ports in turn) and emits the transposed
// triplets, taking no new triplet from the queue until the final one is out.
// After reset a pass clears all MAX_DIM column counts, during which no input
// is taken; register writes are taken at any time.
// ----------------------------------------------------------------------------
`include "sparse_triplet_transpose_defines.svh"

module sparse_triplet_transpose #(
  parameter int MAX_NONZERO = stt_pkg::DEF_MAX_NONZERO,
  parameter int MAX_DIM     = stt_pkg::DEF_MAX_DIM,
  parameter int VALUE_WIDTH = stt_pkg::DEF_VALUE_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  stt_in_if.sink                      in_port,
  stt_out_if.source                   out_port,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stt_pkg::PADDR_W-1:0] paddr,
  input  logic [stt_pkg::PDATA_W-1:0] pwdata,
  output logic [stt_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import stt_pkg::*;

  stt_qstat_t q_stat;
  stt_bstat_t b_stat;
  logic       push_valid;
  stt_item_t  push_data;
  logic       pop_valid;
  logic       pop_ready;
  stt_item_t  pop_data;

  stt_front #(
    .MAX_DIM (MAX_DIM)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_port    (in_port),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .q_stat     (q_stat),
    .b_stat     (b_stat),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .q_stat     (q_stat)
  );

  stt_back #(
    .MAX_NONZERO (MAX_NONZERO),
    .MAX_DIM     (MAX_DIM),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .b_stat    (b_stat),
    .out_port  (out_port)
  );

  `STT_ASSERT_NOW(a_no_input_in_clear, in_port.valid && in_port.ready, !b_stat.clearing, "input transfer during count clearing pass")
  `STT_ASSERT_NOW(a_out_only_emitting, out_port.valid, b_stat.emitting, "result valid outside emission")
  `STT_ASSERT_NEXT(a_last_ends_matrix, out_port.valid && out_port.ready && out_port.out_last, !out_port.valid, "result after final transfer of a matrix")
  `STT_ASSERT_NOW(a_queue_level_sane, 1'b1, !(q_stat.full && q_stat.empty), "queue reports full and empty")

endmodule
